FILE: src/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bla_pkg.sv
package bla_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned AvgW    = 12;
  localparam int unsigned FlagW   = 3;
  localparam int unsigned RegIdxW = 2;

  localparam logic [SampleW-1:0] SampleMax = {SampleW{1'b1}};

  // Configuration register indexes.
  localparam logic [RegIdxW-1:0] REG_LOW5  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_LOW20 = 2'd1;
  localparam logic [RegIdxW-1:0] REG_LOW50 = 2'd2;

  // Threshold reset values.
  localparam logic [AvgW-1:0] Low5Rst  = 12'hCC;
  localparam logic [AvgW-1:0] Low20Rst = 12'h333;
  localparam logic [AvgW-1:0] Low50Rst = 12'h7FF;

  // Level flag bit positions.
  localparam int unsigned FlagLow5  = 0;
  localparam int unsigned FlagLow20 = 1;
  localparam int unsigned FlagLow50 = 2;

  typedef enum logic [1:0] {
    ALARM_NONE  = 2'd0,
    ALARM_LOW5  = 2'd1,
    ALARM_LOW20 = 2'd2,
    ALARM_LOW50 = 2'd3
  } alarm_e;

  typedef struct packed {
    logic [AvgW-1:0] low5;
    logic [AvgW-1:0] low20;
    logic [AvgW-1:0] low50;
  } thr_t;

endpackage

FILE: src/bla_if.sv
interface bla_in_if;
  import bla_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               on_battery;

  modport source (output valid, sample, on_battery, input ready);
  modport sink (input valid, sample, on_battery, output ready);
endinterface

interface bla_out_if;
  import bla_pkg::*;

  logic             valid;
  logic             ready;
  logic [AvgW-1:0]  average;
  logic [FlagW-1:0] level_flags;
  logic [1:0]       alarm;
  logic             notify_remote;

  modport source (output valid, average, level_flags, alarm, notify_remote, input ready);
  modport sink (input valid, average, level_flags, alarm, notify_remote, output ready);
endinterface

interface bla_cfg_if;
  import bla_pkg::*;

  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] reg_idx;
  logic [AvgW-1:0]    wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

FILE: src/bla_cfg.sv
module bla_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  bla_cfg_if.sink       cfg_i,
  output bla_pkg::thr_t thr_o
);
  import bla_pkg::*;

  thr_t thr_q, thr_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    thr_d = thr_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.reg_idx)
        REG_LOW5:  thr_d.low5  = cfg_i.wdata;
        REG_LOW20: thr_d.low20 = cfg_i.wdata;
        REG_LOW50: thr_d.low50 = cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.low5  <= Low5Rst;
      thr_q.low20 <= Low20Rst;
      thr_q.low50 <= Low50Rst;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

FILE: src/bla_accum.sv
module bla_accum #(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned SumW   = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bla_in_if.sink          in_i,
  output logic            sum_vld_o,
  input  logic            sum_rdy_i,
  output logic [SumW-1:0] sum_o
);
  import bla_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW + 1);

  logic            win_q, win_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] acc_q, acc_d;
  logic            vld_q, vld_d;
  logic [SumW-1:0] sum_q, sum_d;

  logic            accept;
  logic [SumW-1:0] acc_next;
  logic [CntW-1:0] cnt_next;
  logic            done;

  // The output register moves on whenever it is empty or being drained.
  assign in_i.ready = !vld_q || sum_rdy_i;
  assign accept     = in_i.valid && in_i.ready;

  // The accumulator and count sit at zero whenever no window is open.
  assign acc_next = acc_q + SumW'(in_i.sample);
  assign cnt_next = cnt_q + CntW'(1);
  assign done     = (cnt_next == CntW'(WINDOW));

  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    vld_d = vld_q && !sum_rdy_i;
    sum_d = sum_q;
    if (accept && (win_q || in_i.on_battery)) begin
      if (done) begin
        win_d = 1'b0;
        cnt_d = '0;
        acc_d = '0;
        vld_d = 1'b1;
        sum_d = acc_next;
      end else begin
        win_d = 1'b1;
        cnt_d = cnt_next;
        acc_d = acc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 1'b0;
      cnt_q <= '0;
      acc_q <= '0;
      vld_q <= 1'b0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_vld_o = vld_q;
  assign sum_o     = sum_q;

endmodule

FILE: src/bla_avg.sv
module bla_avg #(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned SumW   = 18
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     sum_vld_i,
  output logic                     sum_rdy_o,
  input  logic [SumW-1:0]          sum_i,
  output logic                     avg_vld_o,
  input  logic                     avg_rdy_i,
  output logic [bla_pkg::AvgW-1:0] avg_o
);
  import bla_pkg::*;

  // Floor division by the window length as a multiply by a rounded-up
  // reciprocal. With the shift at least SumW plus the bits of WINDOW the
  // rounding error never reaches the next integer, so no correction is needed.
  localparam int unsigned CntW   = $clog2(WINDOW + 1);
  localparam int unsigned Shift  = SumW + CntW;
  localparam int unsigned RecipM = ((2 ** Shift) + WINDOW - 1) / WINDOW;
  localparam int unsigned ProdW  = SumW + Shift + 1;

  logic [ProdW-1:0] prod;
  logic             vld_q, vld_d;
  logic [AvgW-1:0]  avg_q, avg_d;
  logic             load;

  assign prod      = ProdW'(sum_i) * ProdW'(RecipM);
  assign sum_rdy_o = !vld_q || avg_rdy_i;
  assign load      = sum_vld_i && sum_rdy_o;

  always_comb begin
    vld_d = vld_q && !avg_rdy_i;
    avg_d = avg_q;
    if (load) begin
      vld_d = 1'b1;
      avg_d = prod[Shift +: AvgW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
  end

  assign avg_vld_o = vld_q;
  assign avg_o     = avg_q;

endmodule

FILE: src/bla_level.sv
module bla_level (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     avg_vld_i,
  output logic                     avg_rdy_o,
  input  logic [bla_pkg::AvgW-1:0] avg_i,
  input  bla_pkg::thr_t            thr_i,
  bla_out_if.source                out_o
);
  import bla_pkg::*;

  logic [FlagW-1:0] flags_q, flags_d;
  logic             vld_q, vld_d;
  logic [AvgW-1:0]  avg_q, avg_d;
  alarm_e           alarm_q, alarm_d;
  logic             remote_q, remote_d;

  logic [FlagW-1:0] flags_new;
  alarm_e           alarm_new;
  logic             remote_new;
  logic             load;

  assign avg_rdy_o = !vld_q || out_o.ready;
  assign load      = avg_vld_i && avg_rdy_o;

  // Cascade: bands the average is not under are cleared, bands above its own
  // keep their flags. Only a flag that goes from clear to set raises an alarm.
  always_comb begin
    flags_new  = flags_q;
    alarm_new  = ALARM_NONE;
    remote_new = 1'b0;
    if (avg_i < thr_i.low5) begin
      if (!flags_q[FlagLow5]) begin
        flags_new[FlagLow5] = 1'b1;
        alarm_new           = ALARM_LOW5;
      end
    end else begin
      flags_new[FlagLow5] = 1'b0;
      if (avg_i < thr_i.low20) begin
        if (!flags_q[FlagLow20]) begin
          flags_new[FlagLow20] = 1'b1;
          alarm_new            = ALARM_LOW20;
          remote_new           = 1'b1;
        end
      end else begin
        flags_new[FlagLow20] = 1'b0;
        if (avg_i < thr_i.low50) begin
          if (!flags_q[FlagLow50]) begin
            flags_new[FlagLow50] = 1'b1;
            alarm_new            = ALARM_LOW50;
            remote_new           = 1'b1;
          end
        end else begin
          flags_new[FlagLow50] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    flags_d  = flags_q;
    vld_d    = vld_q && !out_o.ready;
    avg_d    = avg_q;
    alarm_d  = alarm_q;
    remote_d = remote_q;
    if (load) begin
      flags_d  = flags_new;
      vld_d    = 1'b1;
      avg_d    = avg_i;
      alarm_d  = alarm_new;
      remote_d = remote_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      flags_q <= flags_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q    <= avg_d;
    alarm_q  <= alarm_d;
    remote_q <= remote_d;
  end

  assign out_o.valid         = vld_q;
  assign out_o.average       = avg_q;
  assign out_o.level_flags   = flags_q;
  assign out_o.alarm         = alarm_q;
  assign out_o.notify_remote = remote_q;

endmodule

FILE: src/battery_level_alarm_monitor.sv
// Battery level alarm monitor. Takes one 12-bit ADC sample per beat, every
// cycle while the result side takes its beats, with no gaps needed between
// beats. A window opens on a sample that arrives with on_battery set; after
// WINDOW samples the truncated mean is checked against three thresholds
// (under 5%, else under 20%, else under 50%) and one result beat is produced.
// Samples outside a window that arrive with on_battery clear give no result.
// After the window's last sample is taken, the result beat passes the
// accumulator register, the register behind the reciprocal multiply that
// divides by WINDOW, and the register behind the threshold compare and flag
// update. Thresholds are written through the configuration channel (index 0,
// 1, 2 for the 5%, 20% and 50% levels); the user must write them only while
// the block is idle, which it does not enforce. Other indexes are ignored.
module battery_level_alarm_monitor #(
  parameter int unsigned WINDOW = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bla_in_if.sink     in_i,
  bla_cfg_if.sink    cfg_i,
  bla_out_if.source  out_o
);
  import bla_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned SumW = $clog2((WINDOW * SampleMax) + 1);

  thr_t            thr;
  logic            sum_vld;
  logic            sum_rdy;
  logic [SumW-1:0] sum;
  logic            avg_vld;
  logic            avg_rdy;
  logic [AvgW-1:0] avg;

  bla_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .thr_o  (thr)
  );

  bla_accum #(
    .WINDOW (WINDOW),
    .SumW   (SumW)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .sum_vld_o (sum_vld),
    .sum_rdy_i (sum_rdy),
    .sum_o     (sum)
  );

  bla_avg #(
    .WINDOW (WINDOW),
    .SumW   (SumW)
  ) u_avg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sum_vld_i (sum_vld),
    .sum_rdy_o (sum_rdy),
    .sum_i     (sum),
    .avg_vld_o (avg_vld),
    .avg_rdy_i (avg_rdy),
    .avg_o     (avg)
  );

  bla_level u_level (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .avg_vld_i (avg_vld),
    .avg_rdy_o (avg_rdy),
    .avg_i     (avg),
    .thr_i     (thr),
    .out_o     (out_o)
  );

  // A local alarm or no alarm never goes to the remote channels.
  `BLA_ASSERT_IMP(a_remote_route, clk_i, rst_ni,
                  out_o.valid && (out_o.alarm == ALARM_NONE || out_o.alarm == ALARM_LOW5),
                  !out_o.notify_remote, "remote route on local or no alarm")

  // An alarm always comes with its level flag set in the same beat.
  `BLA_ASSERT_IMP(a_alarm_flag, clk_i, rst_ni,
                  out_o.valid && out_o.alarm != ALARM_NONE,
                  out_o.level_flags[out_o.alarm - 2'd1], "alarm without its level flag")

  // A remote alarm reports only the 20% or 50% level.
  `BLA_ASSERT_IMP(a_remote_level, clk_i, rst_ni,
                  out_o.valid && out_o.notify_remote,
                  out_o.alarm == ALARM_LOW20 || out_o.alarm == ALARM_LOW50,
                  "remote route without remote alarm")

  // The three pipeline stages start empty, so no result can follow a reset at once.
  `BLA_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, $rose(rst_ni), !out_o.valid,
                   "result right after reset")

endmodule

FILE: bench/battery_level_alarm_monitor_tb.sv
`timescale 1ns / 100ps

module battery_level_alarm_monitor_tb;
  import bla_pkg::*;

  localparam int unsigned Window       = 10;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned ItemTarget   = 650;
  localparam int unsigned IdlePercent  = 18;

  // Index 3 has no register behind it, so writes to it must be dropped.
  localparam logic [RegIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [AvgW-1:0]  average;
    logic [FlagW-1:0] level_flags;
    alarm_e           alarm;
    logic             notify_remote;
  } level_report_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  bla_in_if  in_if ();
  bla_out_if out_if ();
  bla_cfg_if cfg_if ();

  battery_level_alarm_monitor #(
    .WINDOW(Window)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // Predicted copy of the block's state.
  thr_t             thr_model    = '{low5: Low5Rst, low20: Low20Rst, low50: Low50Rst};
  logic [17:0]      acc_model    = '0;
  logic [6:0]       count_model  = '0;
  logic             window_model = 1'b0;
  logic [FlagW-1:0] flags_model  = '0;

  level_report_t pending_reports[$];

  int          err_count    = 0;
  int          items_sent   = 0;
  int          beats_taken  = 0;
  int          reports_seen = 0;
  int          cfg_writes   = 0;
  int          alarm_hits[4] = '{0, 0, 0, 0};
  bit          gaps_on      = 1'b1;
  int unsigned idle_cycles  = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Folds one accepted sample into the window and queues a report when the
  // window completes.
  function automatic void fold_sample(input logic [SampleW-1:0] s, input logic on_batt);
    level_report_t rep;
    logic [AvgW-1:0] avg;
    if (!window_model) begin
      if (!on_batt) return;
      window_model = 1'b1;
      acc_model    = '0;
      count_model  = '0;
    end
    acc_model   = acc_model + s;
    count_model = count_model + 1'b1;
    if (count_model < Window) return;

    avg          = AvgW'(acc_model / Window);
    window_model = 1'b0;
    acc_model    = '0;
    count_model  = '0;

    rep.alarm         = ALARM_NONE;
    rep.notify_remote = 1'b0;
    // Cascade: a lower band keeps the flags of the bands above it.
    if (avg < thr_model.low5) begin
      if (!flags_model[FlagLow5]) begin
        flags_model[FlagLow5] = 1'b1;
        rep.alarm = ALARM_LOW5;
      end
    end else begin
      flags_model[FlagLow5] = 1'b0;
      if (avg < thr_model.low20) begin
        if (!flags_model[FlagLow20]) begin
          flags_model[FlagLow20] = 1'b1;
          rep.alarm         = ALARM_LOW20;
          rep.notify_remote = 1'b1;
        end
      end else begin
        flags_model[FlagLow20] = 1'b0;
        if (avg < thr_model.low50) begin
          if (!flags_model[FlagLow50]) begin
            flags_model[FlagLow50] = 1'b1;
            rep.alarm         = ALARM_LOW50;
            rep.notify_remote = 1'b1;
          end
        end else begin
          flags_model[FlagLow50] = 1'b0;
        end
      end
    end
    rep.average     = avg;
    rep.level_flags = flags_model;
    pending_reports.push_back(rep);
  endfunction

  // Checker, predictor update and watchdog, all on the rising edge.
  always @(posedge clk) begin
    level_report_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        reports_seen++;
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("report beat with nothing pending, average %0d",
                                    out_if.average));
        end else begin
          want = pending_reports.pop_front();
          alarm_hits[int'(want.alarm)]++;
          if (out_if.average !== want.average)
            report_mismatch($sformatf("average %0d, want %0d", out_if.average,
                                      want.average));
          if (out_if.level_flags !== want.level_flags)
            report_mismatch($sformatf("level_flags %b, want %b", out_if.level_flags,
                                      want.level_flags));
          if (out_if.alarm !== want.alarm)
            report_mismatch($sformatf("alarm %0d, want %0d", out_if.alarm,
                                      want.alarm));
          if (out_if.notify_remote !== want.notify_remote)
            report_mismatch($sformatf("notify_remote %b, want %b", out_if.notify_remote,
                                      want.notify_remote));
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        beats_taken++;
        fold_sample(in_if.sample, in_if.on_battery);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        cfg_writes++;
        case (cfg_if.reg_idx)
          REG_LOW5:  thr_model.low5  = cfg_if.wdata;
          REG_LOW20: thr_model.low20 = cfg_if.wdata;
          REG_LOW50: thr_model.low50 = cfg_if.wdata;
          default: ;
        endcase
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= gaps_on ? ($urandom_range(99) >= IdlePercent) : 1'b1;
  end

  function automatic logic [SampleW-1:0] clip_sample(input int v);
    if (v < 0) return '0;
    if (v > int'(SampleMax)) return SampleMax;
    return v[SampleW-1:0];
  endfunction

  // Valid stays high on return so that back-to-back beats need no gap.
  task automatic send_sample(input logic [SampleW-1:0] s, input logic on_batt);
    while (gaps_on && $urandom_range(99) < IdlePercent) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.sample     <= s;
    in_if.on_battery <= on_batt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_window(input int center, input int spread);
    int offs;
    for (int i = 0; i < Window; i++) begin
      offs = int'($urandom_range(2 * spread)) - spread;
      send_sample(clip_sample(center + offs), (i == 0) ? 1'b1 : 1'($urandom_range(1)));
    end
  endtask

  // Holds the sender until every pending report is back and the pipeline
  // has had time to empty.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [RegIdxW-1:0] idx, input logic [AvgW-1:0] data);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_thresholds(input logic [AvgW-1:0] l5, input logic [AvgW-1:0] l20,
                                  input logic [AvgW-1:0] l50);
    drain_results();
    write_threshold(REG_LOW5, l5);
    write_threshold(REG_LOW20, l20);
    write_threshold(REG_LOW50, l50);
  endtask

  task automatic test_directed_extremes();
    // No window is open, so beats with on_battery low are dropped.
    send_sample(SampleMax, 1'b0);
    send_sample('0, 1'b0);
    // Once open, the window ignores on_battery on its later beats.
    send_sample('0, 1'b1);
    for (int i = 1; i < Window; i++)
      send_sample((i == 5) ? 12'd1 : 12'd0, 1'(i));
    // A full-scale window lifts the average above every band.
    for (int i = 0; i < Window; i++)
      send_sample(SampleMax, (i == 0) ? 1'b1 : 1'b0);
    send_sample(12'h555, 1'b0);
    drain_results();
  endtask

  task automatic test_threshold_settings();
    int sets[6][3] = '{'{0, 0, 0}, '{4095, 4095, 4095}, '{3000, 1000, 2000},
                       '{100, 2000, 4000}, '{4095, 0, 4095},
                       '{int'(Low5Rst), int'(Low20Rst), int'(Low50Rst)}};
    for (int k = 0; k < 6; k++) begin
      apply_thresholds(AvgW'(sets[k][0]), AvgW'(sets[k][1]), AvgW'(sets[k][2]));
      // An average equal to a threshold is not under it.
      send_window(int'(thr_model.low5), 0);
      send_window(int'(thr_model.low20) - 1, 0);
      send_window(int'(thr_model.low50), 3);
      send_window($urandom_range(1) ? int'(SampleMax) : 0, 0);
      if (k == 2) begin
        drain_results();
        write_threshold(RegSpare, AvgW'($urandom_range(int'(SampleMax))));
        send_window(int'(thr_model.low5) - 2, 1);
      end
    end
    drain_results();
  endtask

  task automatic test_random_windows();
    int  pick;
    int  center;
    int  len;
    bit  paused = 1'b0;
    while (items_sent < ItemTarget) begin
      gaps_on = !(items_sent >= 330 && items_sent < 460);
      if (!paused && items_sent >= 500) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 72) begin
        case ($urandom_range(4))
          0: center = int'(thr_model.low5);
          1: center = int'(thr_model.low20);
          2: center = int'(thr_model.low50);
          3: center = $urandom_range(int'(SampleMax));
          default: center = $urandom_range(1) ? int'(SampleMax) : 0;
        endcase
        send_window(center, $urandom_range(12));
      end else if (pick < 88) begin
        len = $urandom_range(1, 3);
        repeat (len) send_sample(SampleW'($urandom), 1'b0);
      end else begin
        // A short run that may leave a window open for the next sequence.
        len = $urandom_range(1, Window - 1);
        repeat (len) send_sample(SampleW'($urandom), 1'($urandom_range(1)));
      end
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.sample     = '0;
    in_if.on_battery = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_idx   = REG_LOW5;
    cfg_if.wdata     = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_threshold_settings();
    test_random_windows();

    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

    $display("covered %0d sample beats, %0d level reports and %0d register writes",
             beats_taken, reports_seen, cfg_writes);
    $display("alarms seen: none %0d, under5 %0d, under20 %0d, under50 %0d",
             alarm_hits[0], alarm_hits[1], alarm_hits[2], alarm_hits[3]);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: battery_level_alarm_monitor.f
+incdir+src
src/bla_pkg.sv
src/bla_if.sv
src/bla_cfg.sv
src/bla_accum.sv
src/bla_avg.sv
src/bla_level.sv
src/battery_level_alarm_monitor.sv
bench/battery_level_alarm_monitor_tb.sv
